>>> rtl/core/vrq_pkg.sv
// shared types and constants for the vector ring queue
package vrq_pkg;

   localparam int ID_BITS    = 32;
   localparam int DATA_BITS  = 64;
   localparam int COUNT_BITS = 11;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_GET    = 2'd2,
      FUNC_UPDATE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_PUSHED = 2'd1,
      ST_FULL_EMPTY = 2'd2,
      ST_ABSENT     = 2'd3
   } status_type;

endpackage

>>> rtl/core/vrq_ram.sv
// single-port-write, single-port-read word store with registered read data
module vrq_ram #(
   parameter int DEPTH     = 1024,
   parameter int WIDTH     = 64,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/vector_ring_queue_with_id_access_top.sv
// top level of the vector ring queue with id access
//
// Ring store of CAPACITY words addressed by absolute ids, CAPACITY a power
// of two. Request beats on req_* carry an operation (push, pop, get by id,
// update by id), an id and a word; each request yields exactly one response
// beat on rsp_* with a status, the word read (zero unless a pop or get
// succeeds), the occupancy and the stored size after the operation.
// The response is valid in the cycle after accept, set by the registered
// read port of the word store. Throughput is one beat per cycle while
// req_stall is low: all checks, counter updates and the store access happen
// in the accept cycle. When the receiver raises rsp_stall while a response
// is held, req_stall goes high in the same cycle and the held response and
// read data stay unchanged until taken. Full or empty is reported at once,
// never waited on. Reset clears the push and pop counters and the response
// valid; the store contents are undefined until pushed and no clearing pass
// runs, so requests are taken from the first cycle after reset.
module vector_ring_queue_with_id_access_top #(
   parameter int CAPACITY  = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  vrq_pkg::func_type             req_func,
   input  logic [vrq_pkg::ID_BITS-1:0]   req_vec_id,
   input  logic [vrq_pkg::DATA_BITS-1:0] req_data_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vrq_pkg::status_type           rsp_status,
   output logic [vrq_pkg::DATA_BITS-1:0] rsp_data_out,
   output logic [vrq_pkg::COUNT_BITS-1:0] rsp_occupancy,
   output logic [vrq_pkg::COUNT_BITS-1:0] rsp_stored_size
);
   import vrq_pkg::*;

   localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [ID_BITS-1:0] CAP_COUNT = ID_BITS'(CAPACITY);

   logic [ID_BITS-1:0] push_ff, push_in;
   logic [ID_BITS-1:0] pop_ff, pop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               use_rd_ff, use_rd_in;
   logic [COUNT_BITS-1:0] occ_ff, occ_in;
   logic [COUNT_BITS-1:0] stored_ff, stored_in;

   logic                 accept;
   logic [ID_BITS-1:0]   level;
   logic [ID_BITS-1:0]   level_next;
   logic [ID_BITS-1:0]   id_age;
   logic                 ram_we, ram_re;
   logic [SLOT_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 pop_ok;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign level     = push_ff - pop_ff;
   assign id_age    = push_ff - req_vec_id;

   always_comb begin
      push_in     = push_ff;
      pop_in      = pop_ff;
      status_in   = ST_OK;
      use_rd_in   = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_wr_addr = push_ff[SLOT_BITS-1:0];
      ram_rd_addr = pop_ff[SLOT_BITS-1:0];
      pop_ok      = 1'b0;
      unique case (req_func)
         FUNC_PUSH: begin
            if (level >= CAP_COUNT || push_ff == '1) begin
               status_in = ST_FULL_EMPTY;
            end else begin
               ram_we  = accept;
               push_in = push_ff + ID_BITS'(1);
            end
         end
         FUNC_POP: begin
            if (level == '0) begin
               status_in = ST_FULL_EMPTY;
            end else begin
               ram_re    = accept;
               use_rd_in = 1'b1;
               pop_ok    = accept;
               pop_in    = pop_ff + ID_BITS'(1);
            end
         end
         FUNC_GET: begin
            ram_rd_addr = req_vec_id[SLOT_BITS-1:0];
            if (req_vec_id >= push_ff || id_age > CAP_COUNT) begin
               status_in = ST_ABSENT;
            end else begin
               ram_re    = accept;
               use_rd_in = 1'b1;
            end
         end
         FUNC_UPDATE: begin
            ram_wr_addr = req_vec_id[SLOT_BITS-1:0];
            if (req_vec_id >= push_ff) begin
               status_in = ST_NOT_PUSHED;
            end else begin
               ram_we = accept;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      level_next = push_in - pop_in;
      occ_in     = level_next[COUNT_BITS-1:0];
      stored_in  = (push_in > CAP_COUNT) ? CAP_COUNT[COUNT_BITS-1:0]
                                         : push_in[COUNT_BITS-1:0];
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff      <= '0;
         pop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            push_ff <= push_in;
            pop_ff  <= pop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         use_rd_ff <= use_rd_in;
         occ_ff    <= occ_in;
         stored_ff <= stored_in;
      end
   end

   vrq_ram #(
      .DEPTH     (CAPACITY),
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (SLOT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data_in[WORD_BITS-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_data_out    = use_rd_ff ? DATA_BITS'(ram_rd_data) : '0;
   assign rsp_occupancy   = occ_ff;
   assign rsp_stored_size = stored_ff;

`ifndef NO_ASSERTIONS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (push_ff - pop_ff) <= CAP_COUNT)
      else $error("fill level above capacity");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store written and read by one beat");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request gave no response");

   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      pop_ok |=> pop_ff == $past(pop_ff) + ID_BITS'(1))
      else $error("pop count did not advance");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && use_rd_ff) |-> status_ff == ST_OK)
      else $error("read data returned with failing status");
`endif

endmodule
